[sv/ordered_deque_with_search_delete_assert.svh]
// Assertion macros for the ordered deque checker.
// Needs no package; the caller supplies clock, reset and expressions.
`ifndef ORDERED_DEQUE_WITH_SEARCH_DELETE_ASSERT_SVH
`define ORDERED_DEQUE_WITH_SEARCH_DELETE_ASSERT_SVH

// Consequent must hold on the same edge as the antecedent.
`define ODQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold on the edge after the antecedent.
`define ODQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/odq_pkg.sv]
// Shared sizes, operation and status codes, and cell control types
// for the ordered deque. No dependencies.
package odq_pkg;

	localparam int DEPTH       = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam int MODE_W   = 3;
	localparam int STATUS_W = 2;
	localparam int ENTRY_W  = 32;
	localparam int OCC_W    = 5;

	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_DELETE     = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SEARCH     = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd4;
	localparam logic [MODE_W-1:0] MODE_DUMP_FWD   = 3'd5;
	localparam logic [MODE_W-1:0] MODE_DUMP_BWD   = 3'd6;

	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd3;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_FROM_LEFT,
		CELL_FROM_RIGHT
	} cell_op_t;

	// At most one flag is set in a cycle.
	typedef struct packed {
		logic push_front;
		logic push_back;
		logic del;
		logic rot_fwd;
		logic rot_bwd;
	} chain_cmd_t;

endpackage

[sv/ordered_deque_with_search_delete.sv]
// Ordered deque of up to DEPTH values with push front/back, delete of the first match,
// search, clear and dumps in either direction. A command is taken at a rising edge with
// start high and busy low; busy rises in the next cycle. Push, delete, search and clear
// are carried out in the chain of cells in the EXEC state (compare, first-match ripple and
// shift all at once) and return one beat on strobe in the cycle after, the same cycle busy
// drops, so the next such command is taken only once busy has dropped. A dump returns one
// beat per stored entry on consecutive cycles, taken from the head (or tail) while the
// chain rotates by one position per cycle; busy drops in the same cycle as the last beat.
// An empty dump returns a single beat. Every beat is valid for exactly one cycle and
// cannot be stalled.
module ordered_deque_with_search_delete (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [odq_pkg::MODE_W-1:0]  mode,
	input  logic [31:0]                 value,
	output logic                        busy,
	output logic                        strobe,
	output logic [odq_pkg::STATUS_W-1:0] status,
	output logic                        found,
	output logic [odq_pkg::ENTRY_W-1:0] entry_value,
	output logic [odq_pkg::OCC_W-1:0]   occupancy,
	output logic                        last_of_run
);
	import odq_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_DUMP = 3'b100
	} state_t;

	state_t                 state_q, state_d;
	logic [CNT_W-1:0]       count_q, count_d;
	logic [CNT_W-1:0]       left_q, left_d;
	logic [MODE_W-1:0]      mode_q;
	logic [VALUE_WIDTH-1:0] key_q;

	logic                   strobe_q, emit;
	logic [STATUS_W-1:0]    status_q, status_d;
	logic                   found_q, found_d;
	logic [ENTRY_W-1:0]     entry_q, entry_d;
	logic [OCC_W-1:0]       occ_q;
	logic                   last_q, last_d;

	chain_cmd_t             cmd;
	logic [VALUE_WIDTH-1:0] head, tail;
	logic                   hit;
	logic                   accept, full, empty;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start & ~busy;
	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);

	odq_chain u_chain (
		.clk   (clk),
		.cmd   (cmd),
		.key   (key_q),
		.count (count_q),
		.head  (head),
		.tail  (tail),
		.hit   (hit)
	);

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		count_d  = count_q;
		left_d   = left_q;
		emit     = 1'b0;
		status_d = STAT_OK;
		found_d  = 1'b0;
		entry_d  = '0;
		last_d   = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
				emit    = 1'b1;
				case (mode_q)
					MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
						if (full) begin
							status_d = STAT_FULL;
						end else begin
							cmd.push_front = (mode_q == MODE_PUSH_FRONT);
							cmd.push_back  = (mode_q == MODE_PUSH_BACK);
							count_d        = count_q + CNT_W'(1);
						end
					end
					MODE_DELETE, MODE_SEARCH: begin
						if (empty) begin
							status_d = STAT_EMPTY;
						end else if (!hit) begin
							status_d = STAT_NOT_FOUND;
						end else begin
							found_d = 1'b1;
							if (mode_q == MODE_DELETE) begin
								cmd.del = 1'b1;
								count_d = count_q - CNT_W'(1);
							end
						end
					end
					MODE_CLEAR: begin
						count_d = '0;
					end
					MODE_DUMP_FWD, MODE_DUMP_BWD: begin
						if (empty) begin
							status_d = STAT_EMPTY;
						end else begin
							emit    = 1'b0;
							state_d = ST_DUMP;
							left_d  = count_q;
						end
					end
					default: begin
						emit = 1'b0;
					end
				endcase
			end
			ST_DUMP: begin
				emit   = 1'b1;
				last_d = (left_q == CNT_W'(1));
				left_d = left_q - CNT_W'(1);
				// rotate so the next entry arrives at the tap
				if (mode_q == MODE_DUMP_FWD) begin
					cmd.rot_fwd = 1'b1;
					entry_d     = ENTRY_W'(head);
				end else begin
					cmd.rot_bwd = 1'b1;
					entry_d     = ENTRY_W'(tail);
				end
				if (last_d) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			left_q   <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			left_q   <= left_d;
			strobe_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			key_q  <= VALUE_WIDTH'(value);
		end
		status_q <= status_d;
		found_q  <= found_d;
		entry_q  <= entry_d;
		occ_q    <= OCC_W'(count_d);
		last_q   <= last_d;
	end

	assign strobe      = strobe_q;
	assign status      = status_q;
	assign found       = found_q;
	assign entry_value = entry_q;
	assign occupancy   = occ_q;
	assign last_of_run = last_q;

endmodule

[sv/odq_cell.sv]
// One storage cell of the deque chain: holds one value, compares it
// to the key and ripples the first-match flag. Uses odq_pkg.
module odq_cell (
	input  logic                           clk,
	input  odq_pkg::cell_op_t              op,
	input  logic [odq_pkg::VALUE_WIDTH-1:0] left_val,
	input  logic [odq_pkg::VALUE_WIDTH-1:0] right_val,
	input  logic [odq_pkg::VALUE_WIDTH-1:0] load_val,
	input  logic [odq_pkg::VALUE_WIDTH-1:0] key,
	input  logic                           in_range,
	input  logic                           seen_in,
	output logic [odq_pkg::VALUE_WIDTH-1:0] val,
	output logic                           seen_out
);
	import odq_pkg::*;

	logic [VALUE_WIDTH-1:0] val_q;

	always_ff @(posedge clk) begin
		case (op)
			CELL_HOLD:       val_q <= val_q;
			CELL_LOAD:       val_q <= load_val;
			CELL_FROM_LEFT:  val_q <= left_val;
			CELL_FROM_RIGHT: val_q <= right_val;
			default:         val_q <= val_q;
		endcase
	end

	assign val      = val_q;
	assign seen_out = seen_in | (in_range & (val_q == key));

endmodule

[sv/odq_chain.sv]
// Row of DEPTH cells with per-cell shift control, first-match ripple
// and head/tail taps. Uses odq_pkg and odq_cell.
module odq_chain (
	input  logic                           clk,
	input  odq_pkg::chain_cmd_t            cmd,
	input  logic [odq_pkg::VALUE_WIDTH-1:0] key,
	input  logic [odq_pkg::CNT_W-1:0]      count,
	output logic [odq_pkg::VALUE_WIDTH-1:0] head,
	output logic [odq_pkg::VALUE_WIDTH-1:0] tail,
	output logic                           hit
);
	import odq_pkg::*;

	logic [VALUE_WIDTH-1:0] cell_val [DEPTH];
	logic [DEPTH:0]         seen;
	logic [CNT_W-1:0]       count_m1;

	assign count_m1 = count - CNT_W'(1);
	assign head     = cell_val[0];
	// Only read while the list is non-empty.
	assign tail     = cell_val[count_m1[IDX_W-1:0]];
	assign seen[0]  = 1'b0;
	assign hit      = seen[DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VALUE_WIDTH-1:0] left_w;
		logic [VALUE_WIDTH-1:0] right_w;
		logic [VALUE_WIDTH-1:0] load_w;
		cell_op_t               op_w;
		logic                   is_first;

		if (i == 0) begin : g_first
			assign left_w   = tail;
			assign is_first = 1'b1;
		end else begin : g_mid
			assign left_w   = cell_val[i-1];
			assign is_first = 1'b0;
		end

		if (i == DEPTH - 1) begin : g_end
			assign right_w = head;
		end else begin : g_inner
			assign right_w = cell_val[i+1];
		end

		always_comb begin
			op_w   = CELL_HOLD;
			load_w = key;
			if (cmd.push_front) begin
				op_w = is_first ? CELL_LOAD : CELL_FROM_LEFT;
			end else if (cmd.push_back) begin
				op_w = (CNT_W'(i) == count) ? CELL_LOAD : CELL_HOLD;
			end else if (cmd.del) begin
				// close the gap from the first match onward
				op_w = seen[i+1] ? CELL_FROM_RIGHT : CELL_HOLD;
			end else if (cmd.rot_fwd) begin
				load_w = head;
				op_w   = (CNT_W'(i) == count_m1) ? CELL_LOAD : CELL_FROM_RIGHT;
			end else if (cmd.rot_bwd) begin
				load_w = tail;
				op_w   = is_first ? CELL_LOAD : CELL_FROM_LEFT;
			end
		end

		odq_cell u_cell (
			.clk       (clk),
			.op        (op_w),
			.left_val  (left_w),
			.right_val (right_w),
			.load_val  (load_w),
			.key       (key),
			.in_range  (CNT_W'(i) < count),
			.seen_in   (seen[i]),
			.val       (cell_val[i]),
			.seen_out  (seen[i+1])
		);
	end

endmodule

[sv/odq_checker.sv]
// Port-level checks for the ordered deque, bound to the top level.
// Uses odq_pkg and the assertion macro header.
`include "ordered_deque_with_search_delete_assert.svh"

module odq_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         strobe,
	input logic [odq_pkg::STATUS_W-1:0] status,
	input logic                         found,
	input logic [odq_pkg::OCC_W-1:0]    occupancy,
	input logic                         last_of_run
);
	import odq_pkg::*;

	// a taken command holds off the next one
	`ODQ_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "busy low after accept")
	// a dump beat that is not the last is followed at once by another
	`ODQ_ASSERT_NEXT(a_dump_run, clk, arst_n, strobe && !last_of_run, strobe, "gap in dump run")
	`ODQ_ASSERT_NOW(a_found_ok, clk, arst_n, strobe && found, status == STAT_OK,
		"match reported with bad status")
	`ODQ_ASSERT_NOW(a_occ_max, clk, arst_n, strobe, occupancy <= OCC_W'(DEPTH),
		"occupancy above depth")

endmodule

bind ordered_deque_with_search_delete odq_checker u_odq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.strobe      (strobe),
	.status      (status),
	.found       (found),
	.occupancy   (occupancy),
	.last_of_run (last_of_run)
);

[dv/tb_ordered_deque_with_search_delete.sv]
`timescale 1ns / 1ps
// Self-checking bench for ordered_deque_with_search_delete: directed and random commands,
// a queue-based prediction of the list and beat-by-beat checking of every result.
// Depends on odq_pkg and the block's RTL only.
module tb_ordered_deque_with_search_delete;
	import odq_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
	localparam int RANDOM_COMMANDS = 420;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int TAIL_CYCLES     = DEPTH + 8;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                hit;
		logic [ENTRY_W-1:0]  entry;
		logic [OCC_W-1:0]    occ;
		logic                last_flag;
	} deque_beat_t;

	class deque_scoreboard;
		logic [31:0]  contents[$];
		deque_beat_t  pending_beats[$];
		int unsigned  errors;

		function int pending();
			return pending_beats.size();
		endfunction

		function int find_first(logic [31:0] key);
			foreach (contents[i])
				if (contents[i] == key)
					return i;
			return -1;
		endfunction

		// Update the list for one accepted command and queue the beats it will produce.
		function void note_command(logic [MODE_W-1:0] op, logic [31:0] operand);
			deque_beat_t b;
			int pos;
			int n;
			b.status    = STAT_OK;
			b.hit       = 1'b0;
			b.entry     = '0;
			b.occ       = '0;
			b.last_flag = 1'b1;
			case (op)
				MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
					if (contents.size() >= DEPTH)
						b.status = STAT_FULL;
					else if (op == MODE_PUSH_FRONT)
						contents.push_front(operand);
					else
						contents.push_back(operand);
				end
				MODE_DELETE, MODE_SEARCH: begin
					pos = find_first(operand);
					if (contents.size() == 0)
						b.status = STAT_EMPTY;
					else if (pos < 0)
						b.status = STAT_NOT_FOUND;
					else begin
						b.hit = 1'b1;
						if (op == MODE_DELETE)
							contents.delete(pos);
					end
				end
				MODE_CLEAR: contents.delete();
				MODE_DUMP_FWD, MODE_DUMP_BWD: begin
					n = contents.size();
					if (n == 0)
						b.status = STAT_EMPTY;
					else begin
						for (int i = 0; i < n; i++) begin
							b.entry     = (op == MODE_DUMP_FWD) ? contents[i] : contents[n - 1 - i];
							b.occ       = OCC_W'(n);
							b.last_flag = (i == n - 1);
							pending_beats.push_back(b);
						end
						return;
					end
				end
				default: return;  // unused code: no beat
			endcase
			b.occ = OCC_W'(contents.size());
			pending_beats.push_back(b);
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, field, want, got);
			end
		endfunction

		function void check_beat(deque_beat_t got);
			deque_beat_t want;
			if (pending_beats.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat: expected none, got %p", $time, got);
				return;
			end
			want = pending_beats.pop_front();
			compare_field("status", 32'(want.status), 32'(got.status));
			compare_field("found", 32'(want.hit), 32'(got.hit));
			compare_field("entry_value", want.entry, got.entry);
			compare_field("occupancy", 32'(want.occ), 32'(got.occ));
			compare_field("last_of_run", 32'(want.last_flag), 32'(got.last_flag));
		endfunction
	endclass

	logic                   clk    = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start  = 1'b0;
	logic [MODE_W-1:0]      mode   = '0;
	logic [31:0]            value  = '0;
	logic                   busy;
	logic                   strobe;
	logic [STATUS_W-1:0]    status;
	logic                   found;
	logic [ENTRY_W-1:0]     entry_value;
	logic [OCC_W-1:0]       occupancy;
	logic                   last_of_run;

	deque_scoreboard sb = new();
	logic [31:0]     value_pool[6];
	bit              idling_on = 1'b1;
	int              commands_issued = 0;
	int              stall_cycles = 0;

	ordered_deque_with_search_delete DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.mode        (mode),
		.value       (value),
		.busy        (busy),
		.strobe      (strobe),
		.status      (status),
		.found       (found),
		.entry_value (entry_value),
		.occupancy   (occupancy),
		.last_of_run (last_of_run)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && strobe)
			sb.check_beat({status, found, entry_value, occupancy, last_of_run});
	end

	// Reset the count on any accepted command or result beat.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic logic [31:0] pick_value();
		if ($urandom_range(0, 99) < 75)
			return value_pool[$urandom_range(0, 5)];
		return $urandom();
	endfunction

	task automatic issue(input logic [MODE_W-1:0] op, input logic [31:0] operand);
		int gap;
		while (idling_on && $urandom_range(0, 99) < 31) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 24) : $urandom_range(1, 3);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		mode  <= op;
		value <= operand;
		do @(posedge clk); while (busy);
		sb.note_command(op, operand);
		if (op != MODE_UNUSED)
			commands_issued++;
	endtask

	// Hold the sender until every expected beat has come back.
	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	initial begin
		int n;
		int r;
		value_pool[0] = 32'h0000_0000;
		value_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < 6; i++)
			value_pool[i] = $urandom();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty list, unused code, fill past full, queries, clear.
		issue(MODE_DUMP_BWD, 32'h0);
		issue(MODE_SEARCH, 32'h0);
		issue(MODE_DELETE, 32'h0);
		issue(MODE_UNUSED, 32'hDEAD_BEEF);
		issue(MODE_PUSH_BACK, 32'h0000_0000);
		issue(MODE_PUSH_FRONT, 32'hFFFF_FFFF);
		issue(MODE_PUSH_BACK, 32'hAAAA_AAAA);
		issue(MODE_PUSH_FRONT, 32'h5555_5555);
		issue(MODE_PUSH_BACK, 32'h1234_5678);
		issue(MODE_PUSH_FRONT, 32'h1234_5678);
		for (int i = 6; i < DEPTH; i++)
			issue((i % 2) ? MODE_PUSH_BACK : MODE_PUSH_FRONT, $urandom());
		issue(MODE_PUSH_FRONT, 32'h0BAD_0BAD);
		issue(MODE_PUSH_BACK, 32'h0BAD_0BAD);
		issue(MODE_DUMP_FWD, 32'h0);
		issue(MODE_SEARCH, 32'hFFFF_FFFF);
		issue(MODE_SEARCH, 32'h0000_0001);
		issue(MODE_DELETE, 32'h1234_5678);
		issue(MODE_DELETE, 32'h0000_0001);
		issue(MODE_DUMP_BWD, 32'h0);
		issue(MODE_CLEAR, 32'h0);
		issue(MODE_DUMP_FWD, 32'h0);
		drain_results();

		commands_issued = 0;
		while (commands_issued < RANDOM_COMMANDS) begin
			idling_on = !(commands_issued inside {[150:250]});
			if ($urandom_range(0, 2) == 0)
				value_pool[$urandom_range(2, 5)] = $urandom();
			r = $urandom_range(0, 9);
			if (r <= 2) begin
				n = $urandom_range(4, 20);
				for (int i = 0; i < n; i++)
					issue($urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT, pick_value());
				issue($urandom_range(0, 1) ? MODE_DUMP_FWD : MODE_DUMP_BWD, $urandom());
			end else if (r <= 5) begin
				n = $urandom_range(3, 8);
				for (int i = 0; i < n; i++) begin
					r = $urandom_range(0, 9);
					if (r < 4)
						issue(MODE_SEARCH, pick_value());
					else if (r < 8)
						issue(MODE_DELETE, pick_value());
					else
						issue(r[0] ? MODE_DUMP_FWD : MODE_DUMP_BWD, $urandom());
				end
			end else if (r == 6) begin
				drain_results();
				issue(MODE_CLEAR, $urandom());
				issue($urandom_range(0, 1) ? MODE_DUMP_FWD : MODE_DUMP_BWD, $urandom());
			end else begin
				n = $urandom_range(3, 8);
				for (int i = 0; i < n; i++)
					issue(MODE_W'($urandom_range(0, 7)), $urandom());
			end
		end

		start <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[files.f]
+incdir+sv
sv/odq_pkg.sv
sv/odq_cell.sv
sv/odq_chain.sv
sv/ordered_deque_with_search_delete.sv
sv/odq_checker.sv
dv/tb_ordered_deque_with_search_delete.sv
